@@ hdl/crds_pkg.sv @@
`timescale 1ns / 1ps

package crds_pkg;

    localparam int ADDR_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int CELL_COUNT = 80;
    localparam int ROW_COUNT  = 4;
    localparam int ROW_LENGTH = 20;
    localparam int ROWS_W     = 3;

    localparam logic [BYTE_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [BYTE_W-1:0] DOT_CODE   = 8'h2E;
    localparam logic [BYTE_W-1:0] ESC_CODE   = 8'h1B;
    localparam logic [BYTE_W-1:0] HOME_CODE  = 8'h48;
    localparam logic [BYTE_W-1:0] NUL_CODE   = 8'h00;

    localparam logic [ADDR_W-1:0] ESC_INDEX  = ADDR_W'(CELL_COUNT);
    localparam logic [ADDR_W-1:0] HOME_INDEX = ADDR_W'(CELL_COUNT + 1);
    localparam logic [ADDR_W:0]   HOME_LAST  = (ADDR_W + 1)'(CELL_COUNT + 2);

    localparam logic PANEL_HOMING = 1'b0;
    localparam logic PANEL_ROWS   = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_code;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              clear;
    } cell_req_t;

    function automatic logic [ADDR_W-1:0] row_start(input logic [1:0] pos);
        return ADDR_W'(int'(pos) * ROW_LENGTH);
    endfunction

    function automatic logic [BYTE_W-1:0] row_cmd(input logic [1:0] pos);
        logic [BYTE_W-1:0] code;
        unique case (pos)
            2'd0:    code = 8'h80;
            2'd1:    code = 8'hC0;
            2'd2:    code = 8'h94;
            default: code = 8'hD4;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/char_display_refresh_sequencer_core.sv @@
`timescale 1ns / 1ps

// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------
// input     | start, busy               | command, char_code, location
// result    | result_valid (strobe)     | is_command, panel_byte
// config    | cfg_valid, cfg_ready      | cfg_data (panel type)
//
// A refresh tick that drives the bus passes through ST_IDLE and ST_EMIT: the cell RAM read
// is registered, and the result strobes in ST_EMIT while busy is high.
// Writes, clears, unused commands and silent ticks stay in ST_IDLE and never raise busy.
// Clear drops the per-cell valid flops, so unwritten cells read as space.
// Reset: panel type rows style, refresh at cell 0, buffer all spaces, no sweep.
// The result receiver cannot stall; cfg_ready is always high.

module char_display_refresh_sequencer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] char_code,
    input  logic [6:0] location,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    output logic       result_valid,
    output logic       is_command,
    output logic [7:0] panel_byte
);

    logic                         panel_type_reg;
    logic                         panel_type_next;
    crds_pkg::cell_req_t          cell_req;
    logic [crds_pkg::BYTE_W-1:0]  cell_byte;

    assign cfg_ready       = 1'b1;
    assign panel_type_next = (cfg_valid && cfg_ready) ? cfg_data : panel_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_type_reg <= crds_pkg::PANEL_ROWS;
        end
        else
        begin
            panel_type_reg <= panel_type_next;
        end
    end

    crds_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .char_code   (char_code),
        .location    (location),
        .panel_type  (panel_type_reg),
        .cell_byte   (cell_byte),
        .busy        (busy),
        .cell_req    (cell_req),
        .result_valid(result_valid),
        .is_command  (is_command),
        .panel_byte  (panel_byte)
    );

    crds_cells u_cells (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_req (cell_req),
        .cell_byte(cell_byte)
    );

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_row_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_command) |-> panel_byte[7])
        else $error("instruction byte is not a set-address code");

    a_no_result_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != 2'(crds_pkg::CMD_TICK)) |=> !result_valid)
        else $error("write or clear produced a result");

endmodule

@@ hdl/crds_ram.sv @@
`timescale 1ns / 1ps

module crds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/crds_cells.sv @@
`timescale 1ns / 1ps

module crds_cells (
    input  logic                       clk,
    input  logic                       rst_n,
    input  crds_pkg::cell_req_t        cell_req,
    output logic [crds_pkg::BYTE_W-1:0] cell_byte
);

    logic [crds_pkg::CELL_COUNT-1:0] valid_reg;
    logic [crds_pkg::CELL_COUNT-1:0] valid_next;
    logic                            hit_reg;
    logic [crds_pkg::BYTE_W-1:0]     wr_data;
    logic [crds_pkg::BYTE_W-1:0]     rd_data;

    // control codes are shown as dots
    assign wr_data = (cell_req.wr_code < crds_pkg::SPACE_CODE) ? crds_pkg::DOT_CODE
                                                               : cell_req.wr_code;

    always_comb
    begin
        valid_next = valid_reg;
        if (cell_req.clear)
        begin
            valid_next = '0;
        end
        else if (cell_req.wr_en)
        begin
            valid_next[cell_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cell_req.rd_en)
            begin
                hit_reg <= valid_reg[cell_req.rd_addr];
            end
        end
    end

    crds_ram #(
        .WIDTH(crds_pkg::BYTE_W),
        .DEPTH(crds_pkg::CELL_COUNT)
    ) u_ram (
        .clk    (clk),
        .wr_en  (cell_req.wr_en),
        .wr_addr(cell_req.wr_addr),
        .wr_data(wr_data),
        .rd_en  (cell_req.rd_en),
        .rd_addr(cell_req.rd_addr),
        .rd_data(rd_data)
    );

    // unwritten cells read as space
    assign cell_byte = hit_reg ? rd_data : crds_pkg::SPACE_CODE;

endmodule

@@ hdl/crds_seq.sv @@
`timescale 1ns / 1ps

module crds_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  command,
    input  logic [7:0]                  char_code,
    input  logic [6:0]                  location,
    input  logic                        panel_type,
    input  logic [crds_pkg::BYTE_W-1:0] cell_byte,
    output logic                        busy,
    output crds_pkg::cell_req_t         cell_req,
    output logic                        result_valid,
    output logic                        is_command,
    output logic [7:0]                  panel_byte
);

    crds_pkg::state_t             state_reg;
    crds_pkg::state_t             state_next;
    logic [crds_pkg::ADDR_W-1:0]  idx_reg;
    logic [crds_pkg::ADDR_W-1:0]  idx_next;
    logic [crds_pkg::ROWS_W-1:0]  rows_reg;
    logic [crds_pkg::ROWS_W-1:0]  rows_next;
    logic                         is_cmd_reg;
    logic                         is_cmd_next;
    logic                         use_cell_reg;
    logic                         use_cell_next;
    logic [crds_pkg::BYTE_W-1:0]  byte_reg;
    logic [crds_pkg::BYTE_W-1:0]  byte_next;
    logic                         emit;
    logic                         accept;
    logic                         in_buf;
    logic                         row_due;
    logic [crds_pkg::ADDR_W:0]    idx_inc;
    crds_pkg::cmd_t               cmd;

    assign cmd     = crds_pkg::cmd_t'(command);
    assign accept  = start && !busy;
    assign in_buf  = (idx_reg < crds_pkg::ADDR_W'(crds_pkg::CELL_COUNT));
    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign row_due = (rows_reg < crds_pkg::ROWS_W'(crds_pkg::ROW_COUNT))
                     && (idx_reg == crds_pkg::row_start(rows_reg[1:0]));

    always_comb
    begin
        idx_next      = idx_reg;
        rows_next     = rows_reg;
        is_cmd_next   = is_cmd_reg;
        use_cell_next = use_cell_reg;
        byte_next     = byte_reg;
        emit          = 1'b0;
        cell_req      = '0;
        cell_req.wr_addr = location;
        cell_req.wr_code = char_code;
        cell_req.rd_addr = idx_reg;
        if (accept)
        begin
            unique case (cmd)
                crds_pkg::CMD_TICK:
                begin
                    if (panel_type == crds_pkg::PANEL_ROWS)
                    begin
                        if (row_due)
                        begin
                            rows_next     = rows_reg + 1'b1;
                            emit          = 1'b1;
                            is_cmd_next   = 1'b1;
                            use_cell_next = 1'b0;
                            byte_next     = crds_pkg::row_cmd(rows_reg[1:0]);
                        end
                        else
                        begin
                            emit           = in_buf;
                            cell_req.rd_en = in_buf;
                            is_cmd_next    = 1'b0;
                            use_cell_next  = 1'b1;
                            if (idx_inc >= (crds_pkg::ADDR_W + 1)'(crds_pkg::CELL_COUNT))
                            begin
                                idx_next  = '0;
                                rows_next = '0;
                            end
                            else
                            begin
                                idx_next = idx_inc[crds_pkg::ADDR_W-1:0];
                            end
                        end
                    end
                    else
                    begin
                        emit           = 1'b1;
                        cell_req.rd_en = in_buf;
                        is_cmd_next    = 1'b0;
                        use_cell_next  = in_buf;
                        if (idx_reg == crds_pkg::ESC_INDEX)
                        begin
                            byte_next = crds_pkg::ESC_CODE;
                        end
                        else if (idx_reg == crds_pkg::HOME_INDEX)
                        begin
                            byte_next = crds_pkg::HOME_CODE;
                        end
                        else
                        begin
                            byte_next = crds_pkg::NUL_CODE;
                        end
                        if (idx_inc > crds_pkg::HOME_LAST)
                        begin
                            idx_next = '0;
                        end
                        else
                        begin
                            idx_next = idx_inc[crds_pkg::ADDR_W-1:0];
                        end
                    end
                end
                crds_pkg::CMD_WRITE:
                begin
                    cell_req.wr_en = (location < crds_pkg::ADDR_W'(crds_pkg::CELL_COUNT));
                end
                crds_pkg::CMD_CLEAR:
                begin
                    cell_req.clear = 1'b1;
                    idx_next       = '0;
                    rows_next      = '0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crds_pkg::ST_IDLE: state_next = emit ? crds_pkg::ST_EMIT : crds_pkg::ST_IDLE;
            crds_pkg::ST_EMIT: state_next = crds_pkg::ST_IDLE;
            default:           state_next = crds_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        result_valid = 1'b0;
        unique case (state_reg)
            crds_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            crds_pkg::ST_EMIT:
            begin
                busy         = 1'b1;
                result_valid = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign is_command = is_cmd_reg;
    assign panel_byte = use_cell_reg ? cell_byte : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crds_pkg::ST_IDLE;
            idx_reg   <= '0;
            rows_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rows_reg  <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_cmd_reg   <= is_cmd_next;
        use_cell_reg <= use_cell_next;
        byte_reg     <= byte_next;
    end

endmodule
